// ----- src/mme_pkg.sv -----
`default_nettype none

package mme_pkg;

  // Default sizes of the engine.
  localparam int MaxDimDefault   = 16;
  localparam int ElemBitsDefault = 16;

  // Fixed field widths.
  localparam int SumBits      = 48;
  localparam int IdxBits      = 4;
  localparam int ValueBits    = 16;
  localparam int ActionBits   = 2;
  localparam int CfgDataBits  = 5;
  localparam int CfgIndexBits = 2;

  // Request action codes.
  localparam logic [ActionBits-1:0] ACT_LOAD_A  = 2'd0;
  localparam logic [ActionBits-1:0] ACT_LOAD_B  = 2'd1;
  localparam logic [ActionBits-1:0] ACT_COMPUTE = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIndexBits-1:0] REG_ROWS_OF_A    = 2'd0;
  localparam logic [CfgIndexBits-1:0] REG_INNER_LENGTH = 2'd1;
  localparam logic [CfgIndexBits-1:0] REG_COLS_OF_B    = 2'd2;

  typedef struct packed {
    logic [ActionBits-1:0]       action;
    logic [IdxBits-1:0]          row_index;
    logic [IdxBits-1:0]          col_index;
    logic signed [ValueBits-1:0] element_value;
  } cmd_t;

  typedef struct packed {
    logic signed [SumBits-1:0] product_sum;
    logic [IdxBits-1:0]        out_row;
    logic [IdxBits-1:0]        out_col;
    logic                      last;
  } result_t;

  // Tags travelling alongside each operand pair through the MAC pipeline.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT
  } state_e;

endpackage

`default_nettype wire

// ----- src/mme_ram.sv -----
`default_nettype none

module mme_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(Depth)-1:0] waddr_i,
  input  wire  [Width-1:0]         wdata_i,
  input  wire                      re_i,
  input  wire  [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- src/mme_mac.sv -----
`default_nettype none

module mme_mac #(
  parameter int ElemBits = mme_pkg::ElemBitsDefault
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  mme_pkg::mac_ctrl_t                ctrl_i,
  input  wire  signed [ElemBits-1:0]        a_i,
  input  wire  signed [ElemBits-1:0]        b_i,
  output logic                              done_o,
  output logic signed [mme_pkg::SumBits-1:0] sum_o
);

  import mme_pkg::*;

  localparam int ProdBits = 2 * ElemBits;
  localparam int ExtBits  = (ProdBits > SumBits) ? ProdBits : SumBits;

  mac_ctrl_t                  ctrl1_q, ctrl2_q;
  logic signed [ProdBits-1:0] prod_q;
  logic signed [ExtBits-1:0]  prod_ext;
  logic signed [SumBits-1:0]  acc_q, acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl1_q <= '0;
      ctrl2_q <= '0;
    end else begin
      ctrl1_q <= ctrl_i;
      ctrl2_q <= ctrl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    if (ctrl1_q.valid) begin
      acc_q <= acc_d;
    end
  end

  // The sum wraps modulo 2^48; a product wider than the accumulator is cut to its width.
  assign prod_ext = ExtBits'(prod_q);
  assign acc_d    = ctrl1_q.first ? prod_ext[SumBits-1:0] : acc_q + prod_ext[SumBits-1:0];

  assign done_o = ctrl2_q.valid & ctrl2_q.last;
  assign sum_o  = acc_q;

endmodule

`default_nettype wire

// ----- src/matrix_multiply_engine.sv -----
`default_nettype none

// Dense matrix multiply engine, C = A x B in signed Q1.15 with an exact Q18.30 sum.
// A load request writes one element of A or B. A compute request for a row of C holds
// busy high until the row is done: one shared multiply-accumulate unit is fed one
// operand pair per cycle while a column is issued, from the single read port of each
// store, and after each column the sequencer waits out the read latency and the
// multiply and accumulate stages. Each element of the row is shown for one cycle with
// result_valid_o; the receiver cannot hold results off and must take each one as it
// comes. The final result of a row is shown in the first cycle in which busy is low
// again. The user must write configuration only while busy is low; it is not enforced.
module matrix_multiply_engine #(
  parameter int MAX_DIM   = mme_pkg::MaxDimDefault,
  parameter int ELEM_BITS = mme_pkg::ElemBitsDefault
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                start,
  output logic                               busy,
  input  mme_pkg::cmd_t                      cmd_i,
  input  wire                                cfg_we_i,
  input  wire  [mme_pkg::CfgIndexBits-1:0]   cfg_index_i,
  input  wire  [mme_pkg::CfgDataBits-1:0]    cfg_data_i,
  output logic                               result_valid_o,
  output mme_pkg::result_t                   result_o
);

  import mme_pkg::*;

  localparam int Depth    = MAX_DIM * MAX_DIM;
  localparam int AddrBits = $clog2(Depth);
  localparam int CntBits  = $clog2(MAX_DIM + 1);
  localparam int DimReset = (MAX_DIM < 16) ? MAX_DIM : 16;

  // Configuration registers, held already clamped to 1..MAX_DIM.
  logic [CntBits-1:0] rows_q, inner_q, cols_q, cfg_dim;

  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_dim = CntBits'(1);
    end else if (32'(cfg_data_i) > MAX_DIM) begin
      cfg_dim = CntBits'(MAX_DIM);
    end else begin
      cfg_dim = CntBits'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= CntBits'(DimReset);
      inner_q <= CntBits'(DimReset);
      cols_q  <= CntBits'(DimReset);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ROWS_OF_A:    rows_q  <= cfg_dim;
        REG_INNER_LENGTH: inner_q <= cfg_dim;
        REG_COLS_OF_B:    cols_q  <= cfg_dim;
        default:          ;
      endcase
    end
  end

  // Request decode.
  logic                accept, idx_ok, row_ok;
  logic                we_a, we_b;
  logic [AddrBits-1:0] load_addr, row_base;
  logic [ELEM_BITS-1:0] load_data;

  assign accept    = start & ~busy;
  assign idx_ok    = (32'(cmd_i.row_index) < MAX_DIM) && (32'(cmd_i.col_index) < MAX_DIM);
  assign row_ok    = (32'(cmd_i.row_index) < MAX_DIM) && (32'(cmd_i.row_index) < 32'(rows_q));
  assign load_addr = AddrBits'(32'(cmd_i.row_index) * MAX_DIM + 32'(cmd_i.col_index));
  assign row_base  = AddrBits'(32'(cmd_i.row_index) * MAX_DIM);
  assign load_data = ELEM_BITS'(cmd_i.element_value);
  assign we_a      = accept && (cmd_i.action == ACT_LOAD_A) && idx_ok;
  assign we_b      = accept && (cmd_i.action == ACT_LOAD_B) && idx_ok;

  // Sequencer.
  state_e              state_q, state_d;
  logic [IdxBits-1:0]  row_q, row_d;
  logic [AddrBits-1:0] base_q, base_d;
  logic [AddrBits-1:0] a_addr_q, a_addr_d, b_addr_q, b_addr_d;
  logic [CntBits-1:0]  k_q, k_d, j_q, j_d;
  mac_ctrl_t           issue_d, issue_q;
  logic                rd_en;
  logic                res_valid_d, res_valid_q;
  result_t             res_d, res_q;
  logic                mac_done;
  logic signed [SumBits-1:0] mac_sum;
  logic                k_last, j_last;

  assign k_last = (k_q + CntBits'(1)) == inner_q;
  assign j_last = (j_q + CntBits'(1)) == cols_q;

  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    base_d      = base_q;
    a_addr_d    = a_addr_q;
    b_addr_d    = b_addr_q;
    k_d         = k_q;
    j_d         = j_q;
    issue_d     = '0;
    rd_en       = 1'b0;
    res_valid_d = 1'b0;
    res_d       = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (cmd_i.action == ACT_COMPUTE) && row_ok) begin
          row_d    = cmd_i.row_index;
          base_d   = row_base;
          a_addr_d = row_base;
          b_addr_d = '0;
          k_d      = '0;
          j_d      = '0;
          state_d  = S_ISSUE;
        end
      end
      S_ISSUE: begin
        rd_en         = 1'b1;
        issue_d.valid = 1'b1;
        issue_d.first = (k_q == '0);
        issue_d.last  = k_last;
        k_d           = k_q + CntBits'(1);
        a_addr_d      = a_addr_q + AddrBits'(1);
        b_addr_d      = b_addr_q + AddrBits'(MAX_DIM);
        if (k_last) begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (mac_done) begin
          res_valid_d       = 1'b1;
          res_d.product_sum = mac_sum;
          res_d.out_row     = row_q;
          res_d.out_col     = IdxBits'(j_q);
          res_d.last        = j_last;
          if (j_last) begin
            state_d = S_IDLE;
          end else begin
            // Next column: walk row r of A again and column j+1 of B.
            j_d      = j_q + CntBits'(1);
            k_d      = '0;
            a_addr_d = base_q;
            b_addr_d = AddrBits'(j_q) + AddrBits'(1);
            state_d  = S_ISSUE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issue_q     <= '0;
      res_valid_q <= 1'b0;
      k_q         <= '0;
      j_q         <= '0;
    end else begin
      state_q     <= state_d;
      issue_q     <= issue_d;
      res_valid_q <= res_valid_d;
      k_q         <= k_d;
      j_q         <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q    <= row_d;
    base_q   <= base_d;
    a_addr_q <= a_addr_d;
    b_addr_q <= b_addr_d;
    res_q    <= res_d;
  end

  // Element stores and the shared multiply-accumulate unit.
  logic [ELEM_BITS-1:0] a_rd, b_rd;

  mme_ram #(
    .Width (ELEM_BITS),
    .Depth (Depth)
  ) u_left_store (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (load_addr),
    .wdata_i (load_data),
    .re_i    (rd_en),
    .raddr_i (a_addr_q),
    .rdata_o (a_rd)
  );

  mme_ram #(
    .Width (ELEM_BITS),
    .Depth (Depth)
  ) u_right_store (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (load_addr),
    .wdata_i (load_data),
    .re_i    (rd_en),
    .raddr_i (b_addr_q),
    .rdata_o (b_rd)
  );

  mme_mac #(
    .ElemBits (ELEM_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (issue_q),
    .a_i    (a_rd),
    .b_i    (b_rd),
    .done_o (mac_done),
    .sum_o  (mac_sum)
  );

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // A finished dot product only ever arrives while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> (state_q == S_WAIT))
    else $error("dot product finished outside the wait state");

  // The final result of a row leaves the sequencer idle; any other result resumes issuing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last) |-> (state_q == S_IDLE))
    else $error("sequencer still active after the last result of a row");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.last) |-> (state_q == S_ISSUE))
    else $error("row stopped before its last column");

  // The inner index never runs past the configured length while issuing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ISSUE) |-> (k_q < inner_q))
    else $error("inner index beyond the dot product length");

endmodule

`default_nettype wire

// ----- tb/sv/tb_matrix_multiply_engine.sv -----
`timescale 1ns / 100ps

module tb_matrix_multiply_engine;
  import mme_pkg::*;

  localparam int CycleLimit  = 1_000_000;
  localparam int ReportLimit = 10;
  localparam int Depth       = MaxDimDefault * MaxDimDefault;
  localparam int CmdBits     = $bits(cmd_t);

  localparam logic [ActionBits-1:0]      ActUnused = 2'd3;
  localparam logic signed [ValueBits-1:0] ElemMax  = 16'sh7fff;
  localparam logic signed [ValueBits-1:0] ElemMin  = 16'sh8000;

  class row_product_tracker;
    logic signed [ValueBits-1:0] left_elems [Depth];
    logic signed [ValueBits-1:0] right_elems [Depth];
    int unsigned rows, inner, cols;
    result_t due_products [$];
    int unsigned mismatches, products_seen;

    function new();
      rows = MaxDimDefault;
      inner = MaxDimDefault;
      cols = MaxDimDefault;
      mismatches = 0;
      products_seen = 0;
    endfunction

    function void write_dim(logic [CfgIndexBits-1:0] idx, logic [CfgDataBits-1:0] data);
      int unsigned d;
      d = (data == 0) ? 1 : (data > MaxDimDefault) ? MaxDimDefault : data;
      case (idx)
        REG_ROWS_OF_A: rows = d;
        REG_INNER_LENGTH: inner = d;
        REG_COLS_OF_B: cols = d;
        default: ;
      endcase
    endfunction

    function void note_request(cmd_t c);
      result_t p;
      logic signed [SumBits-1:0] acc;
      int unsigned j, k;
      case (c.action)
        ACT_LOAD_A: left_elems[{c.row_index, c.col_index}] = c.element_value;
        ACT_LOAD_B: right_elems[{c.row_index, c.col_index}] = c.element_value;
        ACT_COMPUTE: begin
          if (c.row_index < rows) begin
            for (j = 0; j < cols; j++) begin
              acc = '0;
              // Both operands are signed, so they are widened to the sum width first.
              for (k = 0; k < inner; k++)
                acc = acc + left_elems[c.row_index * MaxDimDefault + k]
                          * right_elems[k * MaxDimDefault + j];
              p.product_sum = acc;
              p.out_row = c.row_index;
              p.out_col = IdxBits'(j);
              p.last = (j == cols - 1);
              due_products.push_back(p);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void note_fault(string msg);
      mismatches++;
      if (mismatches <= ReportLimit) $display("%s", msg);
    endfunction

    function void check_result(result_t got);
      result_t want;
      products_seen++;
      if (due_products.size() == 0) begin
        note_fault($sformatf("unexpected product: row %0d col %0d sum %0d last %0b",
                             got.out_row, got.out_col, got.product_sum, got.last));
        return;
      end
      want = due_products.pop_front();
      if (got.product_sum !== want.product_sum || got.out_row !== want.out_row ||
          got.out_col !== want.out_col || got.last !== want.last)
        note_fault($sformatf({"product mismatch: expected row %0d col %0d sum %0d last %0b, ",
                              "got row %0d col %0d sum %0d last %0b"},
                             want.out_row, want.out_col, want.product_sum, want.last,
                             got.out_row, got.out_col, got.product_sum, got.last));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  cmd_t cmd = '0;
  logic cfg_we = 1'b0;
  logic [CfgIndexBits-1:0] cfg_index = '0;
  logic [CfgDataBits-1:0] cfg_data = '0;
  logic result_valid;
  result_t result;

  row_product_tracker board;
  bit a_loaded [Depth];
  bit b_loaded [Depth];
  int unsigned idle_pct = 0;
  int unsigned n_requests = 0;
  int unsigned n_computes = 0;
  int unsigned n_ignored = 0;
  int unsigned n_settings = 0;

  matrix_multiply_engine i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .result_valid_o (result_valid),
    .result_o       (result)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid) board.check_result(result);
  end

  function automatic logic signed [ValueBits-1:0] rand_elem();
    case ($urandom_range(15))
      0, 1: return ElemMax;
      2, 3: return ElemMin;
      4: return '0;
      default: return ValueBits'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the request was taken.
  task automatic send_request(input cmd_t c);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      cmd = cmd_t'(CmdBits'($urandom));
      @(negedge clk_i);
    end
    start = 1'b1;
    cmd = c;
    do @(posedge clk_i); while (busy);
    board.note_request(c);
    n_requests++;
    @(negedge clk_i);
    start = 1'b0;
  endtask

  task automatic load_elem(input logic [ActionBits-1:0] act, input int unsigned r,
                           input int unsigned c, input logic signed [ValueBits-1:0] v);
    cmd_t req;
    req.action = act;
    req.row_index = IdxBits'(r);
    req.col_index = IdxBits'(c);
    req.element_value = v;
    if (act == ACT_LOAD_A) a_loaded[r * MaxDimDefault + c] = 1'b1;
    else b_loaded[r * MaxDimDefault + c] = 1'b1;
    send_request(req);
  endtask

  // Every element the row will read is loaded first, so no unwritten entry is ever read.
  task automatic compute_row(input int unsigned r);
    cmd_t req;
    int unsigned j, k;
    if (r < board.rows) begin
      for (k = 0; k < board.inner; k++)
        if (!a_loaded[r * MaxDimDefault + k]) load_elem(ACT_LOAD_A, r, k, rand_elem());
      for (k = 0; k < board.inner; k++)
        for (j = 0; j < board.cols; j++)
          if (!b_loaded[k * MaxDimDefault + j]) load_elem(ACT_LOAD_B, k, j, rand_elem());
    end
    req.action = ACT_COMPUTE;
    req.row_index = IdxBits'(r);
    req.col_index = IdxBits'($urandom);
    req.element_value = ValueBits'($urandom);
    n_computes++;
    send_request(req);
  endtask

  task automatic send_ignored(input cmd_t c);
    c.action = ActUnused;
    n_ignored++;
    send_request(c);
  endtask

  task automatic write_reg(input logic [CfgIndexBits-1:0] idx,
                           input logic [CfgDataBits-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk_i);
    cfg_we = 1'b0;
    board.write_dim(idx, data);
  endtask

  task automatic set_sizes(input logic [CfgDataBits-1:0] r, input logic [CfgDataBits-1:0] i,
                           input logic [CfgDataBits-1:0] c);
    write_reg(REG_ROWS_OF_A, r);
    write_reg(REG_INNER_LENGTH, i);
    write_reg(REG_COLS_OF_B, c);
    n_settings++;
  endtask

  task automatic drain();
    while (board.due_products.size() != 0 || busy) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic random_step();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      if ($urandom_range(99) < 85 || board.rows == MaxDimDefault)
        compute_row($urandom_range(board.rows - 1));
      else
        compute_row($urandom_range(MaxDimDefault - 1, board.rows));
    end else if (pick < 80) begin
      if ($urandom_range(1))
        load_elem(ACT_LOAD_A, $urandom_range(board.rows - 1), $urandom_range(board.inner - 1),
                  rand_elem());
      else
        load_elem(ACT_LOAD_B, $urandom_range(board.inner - 1), $urandom_range(board.cols - 1),
                  rand_elem());
    end else if (pick < 92) begin
      load_elem($urandom_range(1) ? ACT_LOAD_A : ACT_LOAD_B, $urandom_range(MaxDimDefault - 1),
                $urandom_range(MaxDimDefault - 1), rand_elem());
    end else begin
      send_ignored(cmd_t'(CmdBits'($urandom)));
    end
  endtask

  // The budget of a phase counts every request sent, the loads that fill a row included.
  task automatic run_phase(input logic [CfgDataBits-1:0] r, input logic [CfgDataBits-1:0] i,
                           input logic [CfgDataBits-1:0] c, input int unsigned steps,
                           input int unsigned gap);
    int unsigned first_req;
    drain();
    set_sizes(r, i, c);
    idle_pct = gap;
    first_req = n_requests;
    while (n_requests - first_req < steps) random_step();
  endtask

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("matrix_multiply_engine verification failed");
    $finish;
  end

  initial begin
    int p;
    board = new();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Small two by two case with extreme operands, then rows outside the range in use.
    set_sizes(5'd2, 5'd2, 5'd2);
    load_elem(ACT_LOAD_A, 0, 0, ElemMax);
    load_elem(ACT_LOAD_A, 0, 1, ElemMin);
    load_elem(ACT_LOAD_A, 1, 0, ElemMin);
    load_elem(ACT_LOAD_A, 1, 1, ElemMin);
    load_elem(ACT_LOAD_B, 0, 0, ElemMax);
    load_elem(ACT_LOAD_B, 1, 0, ElemMin);
    load_elem(ACT_LOAD_B, 0, 1, ElemMin);
    load_elem(ACT_LOAD_B, 1, 1, ElemMin);
    compute_row(0);
    compute_row(1);
    compute_row(2);
    compute_row(MaxDimDefault - 1);
    send_ignored('1);
    load_elem(ACT_LOAD_A, MaxDimDefault - 1, MaxDimDefault - 1, ElemMax);
    load_elem(ACT_LOAD_B, MaxDimDefault - 1, MaxDimDefault - 1, -16'sd1);
    load_elem(ACT_LOAD_A, 0, 0, '0);
    compute_row(0);
    load_elem(ACT_LOAD_A, 0, 0, -16'sd1);
    load_elem(ACT_LOAD_B, 0, 0, 16'sd1);
    compute_row(0);
    compute_row(1);

    run_phase(5'd1, 5'd1, 5'd1, 20, 0);
    run_phase(5'd0, 5'd0, 5'd0, 10, 63);
    run_phase(5'd4, 5'd3, 5'd5, 30, 0);
    run_phase(5'd16, 5'd1, 5'd16, 25, 14);
    run_phase(5'd3, 5'd7, 5'd2, 25, 63);
    run_phase(5'd31, 5'd2, 5'd31, 35, 0);
    for (p = 0; p < 5; p++)
      run_phase(CfgDataBits'($urandom_range(1, 6)), CfgDataBits'($urandom_range(1, 6)),
                CfgDataBits'($urandom_range(1, 6)), 16, (p % 3 == 0) ? 63 : (p % 3 == 1) ? 14 : 0);
    run_phase(5'd2, 5'd18, 5'd1, 35, 14);

    start = 1'b0;
    drain();
    repeat (32) @(negedge clk_i);

    $display("Run took %0d requests: %0d row computes and %0d unused codes",
             n_requests, n_computes, n_ignored);
    $display("over %0d size settings; %0d products compared, %0d faults found.",
             n_settings, board.products_seen, board.mismatches);
    if (board.mismatches == 0 && board.due_products.size() == 0) begin
      $display("matrix_multiply_engine verification clean");
    end else begin
      $display("matrix_multiply_engine verification failed");
    end
    $finish;
  end

endmodule
